### rtl/udi_pkg.sv
// Shared types and constants for the unsigned divide-by-invariant block.
package udi_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int OP_WIDTH       = 32;

	localparam logic CMD_SET    = 1'b0;
	localparam logic CMD_DIVIDE = 1'b1;

	typedef struct packed {
		logic load;
		logic cnt_step;
		logic prep;
		logic div_step;
		logic commit;
		logic mul;
		logic sub;
		logic add;
	} udi_cmd_t;

	typedef struct packed {
		logic in_zero;
		logic sr_zero;
		logic div_last;
	} udi_stat_t;

endpackage

### rtl/udi_ctrl.sv
// Control state machine: sequences divisor setup and divide transfers.
module udi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	output logic                out_valid,
	input  logic                out_ready,
	input  udi_pkg::udi_stat_t  stat,
	output udi_pkg::udi_cmd_t   cmd
);
	import udi_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_COUNT  = 8'b0000_0010,
		ST_PREP   = 8'b0000_0100,
		ST_DIV    = 8'b0000_1000,
		ST_COMMIT = 8'b0001_0000,
		ST_MUL    = 8'b0010_0000,
		ST_SUB    = 8'b0100_0000,
		ST_ADD    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (command == CMD_DIVIDE) state_d = ST_MUL;
					else if (stat.in_zero)     state_d = ST_COMMIT;
					else                       state_d = ST_COUNT;
				end
			end
			ST_COUNT:  if (stat.sr_zero) state_d = ST_PREP;
			ST_PREP:   state_d = ST_DIV;
			ST_DIV:    if (stat.div_last) state_d = ST_COMMIT;
			ST_COMMIT: if (out_free) state_d = ST_IDLE;
			ST_MUL:    state_d = ST_SUB;
			ST_SUB:    state_d = ST_ADD;
			ST_ADD:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.cnt_step = (state_q == ST_COUNT) && !stat.sr_zero;
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.commit   = (state_q == ST_COMMIT) && out_free;
		cmd.mul      = (state_q == ST_MUL);
		cmd.sub      = (state_q == ST_SUB);
		cmd.add      = (state_q == ST_ADD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit || cmd.add) out_valid_q <= 1'b1;
			else if (out_ready)        out_valid_q <= 1'b0;
		end
	end

	// a held result blocks completion
	a_hold_add: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD && !out_free |=> state_q == ST_ADD)
		else $error("divide completed over an untaken result");
	a_div_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_DIVIDE |=> state_q == ST_MUL)
		else $error("divide transfer did not enter multiply");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit || cmd.add |=> out_valid_q && state_q == ST_IDLE)
		else $error("completion did not present a result");

endmodule

### rtl/udi_dpath.sv
// Datapath: bit length count, restoring divider, multiplier and correction.
module udi_dpath #(
	parameter int DATA_WIDTH = udi_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [udi_pkg::OP_WIDTH-1:0]  operand,
	input  udi_pkg::udi_cmd_t             cmd,
	output udi_pkg::udi_stat_t            stat,
	output logic [udi_pkg::OP_WIDTH-1:0]  quotient,
	output logic                          divisor_error
);
	import udi_pkg::*;

	localparam int W   = DATA_WIDTH;
	localparam int PW  = 2 * DATA_WIDTH;
	localparam int LGW = $clog2(DATA_WIDTH + 1);
	localparam int SHW = $clog2(DATA_WIDTH);
	localparam int CW  = $clog2(DATA_WIDTH);

	logic [W-1:0]   x_q, sr_q, rem_q, qt_q, hi_q, diff_q, res_q, m_q;
	logic [LGW-1:0] lg_q;
	logic [CW-1:0]  cnt_q;
	logic [SHW-1:0] s2_q;
	logic           s1_q, d_zero_q, err_q;

	logic [W-1:0]   in_word;
	logic [W:0]     pow, top_w, trial, trial_sub;
	logic           ge;
	logic [PW-1:0]  prod;
	logic [W-1:0]   sum;

	assign in_word = operand[W-1:0];

	assign stat.in_zero  = (in_word == '0);
	assign stat.sr_zero  = (sr_q == '0);
	assign stat.div_last = (cnt_q == '0);

	assign pow       = (W+1)'(1) << lg_q;
	assign top_w     = pow - (W+1)'(x_q);
	assign trial     = {rem_q, 1'b0};
	assign ge        = trial >= (W+1)'(x_q);
	assign trial_sub = trial - (W+1)'(x_q);
	assign prod      = PW'(x_q) * PW'(m_q);
	assign sum       = diff_q + hi_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= in_word;
			sr_q     <= in_word - W'(1);
			lg_q     <= '0;
			d_zero_q <= stat.in_zero;
		end
		if (cmd.cnt_step) begin
			sr_q <= sr_q >> 1;
			lg_q <= lg_q + LGW'(1);
		end
		if (cmd.prep) begin
			rem_q <= top_w[W-1:0];
			qt_q  <= '0;
			cnt_q <= CW'(W - 1);
		end
		if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[W-1:0] : trial[W-1:0];
			qt_q  <= {qt_q[W-2:0], ge};
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.mul) hi_q <= prod[PW-1:W];
		if (cmd.sub) diff_q <= (x_q - hi_q) >> s1_q;
		if (cmd.add) begin
			res_q <= sum >> s2_q;
			err_q <= 1'b0;
		end
		if (cmd.commit) begin
			res_q <= '0;
			err_q <= d_zero_q;
		end
	end

	// divisor state; reset value divides by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q  <= W'(1);
			s1_q <= 1'b0;
			s2_q <= '0;
		end else if (cmd.commit && !d_zero_q) begin
			m_q  <= qt_q + W'(1);
			s1_q <= (lg_q != '0);
			s2_q <= (lg_q > LGW'(1)) ? SHW'(lg_q - LGW'(1)) : '0;
		end
	end

	assign quotient      = OP_WIDTH'(res_q);
	assign divisor_error = err_q;

	a_mult_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !d_zero_q |=> m_q != '0)
		else $error("multiplier wrapped to zero");
	a_shift_pair: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_q |-> s2_q == '0)
		else $error("second shift set without first shift");

endmodule

### rtl/unsigned_divide_by_invariant.sv
// Top level: unsigned division by a stored invariant divisor.
// Divide: the operand passes the multiply, subtract and add states; the result is registered.
// Set divisor d: a bit count finds L = ceil(log2 d), then the one-bit-per-cycle restoring divider
//   forms W quotient bits (W data bits); a zero divisor goes straight to the commit state.
// Inputs are refused while an item is in progress; a waiting result holds completion.
// Asynchronous reset selects divisor one (multiplier 1, both shifts 0).
module unsigned_divide_by_invariant #(
	parameter int DATA_WIDTH = udi_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [udi_pkg::OP_WIDTH-1:0]  operand,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [udi_pkg::OP_WIDTH-1:0]  quotient,
	output logic                          divisor_error
);
	import udi_pkg::*;

	udi_cmd_t  cmd;
	udi_stat_t stat;

	udi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	udi_dpath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand       (operand),
		.cmd           (cmd),
		.stat          (stat),
		.quotient      (quotient),
		.divisor_error (divisor_error)
	);

endmodule

### tb/sv/tb_top.sv
// Testbench for unsigned_divide_by_invariant: queued stimulus, bit-exact predictor, scoreboard.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import udi_pkg::*;

	localparam int          ITEM_TOTAL = 1450;
	localparam int          CALM_TAIL  = 150;
	localparam logic [63:0] WORD_MASK  = 64'h0000_0000_ffff_ffff;

	typedef struct packed {
		logic        command;
		logic [31:0] operand;
		logic        drain_first;
	} div_item_t;

	typedef struct packed {
		logic [31:0] quotient;
		logic        divisor_error;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = CMD_SET;
	logic [31:0] operand = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] quotient;
	logic        divisor_error;

	div_item_t pending[$];
	answer_t   quotients_due[$];
	int        offered_cnt = 0;
	int        accepted_cnt = 0;
	int        mismatches = 0;
	int        gap_left = 0;
	int        hold_left = 0;
	logic      long_hold_done = 1'b0;

	// Current reciprocal: divisor one out of reset
	logic [31:0] recip_mult = 32'd1;
	logic        pre_shift = 1'b0;
	logic [4:0]  post_shift = 5'd0;

	unsigned_divide_by_invariant DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.operand(operand),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.quotient(quotient),
		.divisor_error(divisor_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic answer_t predict_quotient(input logic cmd, input logic [31:0] op);
		logic [63:0] d;
		logic [63:0] x;
		logic [63:0] top;
		logic [63:0] m;
		logic [63:0] hi;
		logic [63:0] t;
		logic [63:0] s;
		int unsigned lg;
		answer_t     r;
		r.quotient = '0;
		r.divisor_error = 1'b0;
		if (cmd == CMD_SET) begin
			if (op == '0) begin
				r.divisor_error = 1'b1;
			end else begin
				d = {32'd0, op};
				lg = 0;
				t = d - 64'd1;
				while (t != 0) begin
					t = t >> 1;
					lg++;
				end
				top = ((64'd1 << lg) - d) & WORD_MASK;
				m = ((top << 32) / d) + 64'd1;
				recip_mult = m[31:0];
				pre_shift = (lg >= 1);
				post_shift = (lg > 1) ? 5'(lg - 1) : 5'd0;
			end
		end else begin
			x = {32'd0, op};
			hi = (x * {32'd0, recip_mult}) >> 32;
			t = ((x - hi) & WORD_MASK) >> pre_shift;
			s = (t + hi) & WORD_MASK;
			r.quotient = s[31:0] >> post_shift;
		end
		return r;
	endfunction

	task automatic queue_item(input logic cmd, input logic [31:0] op);
		div_item_t it;
		it.command = cmd;
		it.operand = op;
		it.drain_first = (pending.size() % 480 == 479);
		pending.push_back(it);
	endtask

	// Sender: one item per free slot, random gaps except in the tail and in every fourth 150-item window
	always @(negedge clk) begin
		if (arst_n && accepted_cnt == offered_cnt) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending[0].drain_first && quotients_due.size() != 0) begin
				in_valid <= 1'b0;
			end else if (pending.size() > CALM_TAIL && ((accepted_cnt / 150) % 4) != 3
					&& $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				gap_left <= $urandom_range(0, 7);
			end else begin
				in_valid <= 1'b1;
				command <= pending[0].command;
				operand <= pending[0].operand;
				offered_cnt <= offered_cnt + 1;
				void'(pending.pop_front());
			end
		end
	end

	// Receiver: random stalls plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!long_hold_done && accepted_cnt >= 400) begin
			out_ready <= 1'b0;
			hold_left <= 150;
			long_hold_done <= 1'b1;
		end else if (pending.size() > CALM_TAIL && ((accepted_cnt / 150) % 4) != 1
				&& $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			hold_left <= $urandom_range(0, 7);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Scoreboard: predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				quotients_due.push_back(predict_quotient(command, operand));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (out_valid && out_ready) begin
				if (quotients_due.size() == 0) begin
					$display("%t unexpected result: quotient %h divisor_error %b",
						$time, quotient, divisor_error);
					mismatches++;
				end else begin
					want = quotients_due.pop_front();
					if (quotient !== want.quotient) begin
						$display("%t quotient: expected %h, actual %h",
							$time, want.quotient, quotient);
						mismatches++;
					end
					if (divisor_error !== want.divisor_error) begin
						$display("%t divisor_error: expected %b, actual %b",
							$time, want.divisor_error, divisor_error);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		logic [31:0] d;
		logic [31:0] cur;
		logic [63:0] x;
		int          n;
		int          sel;

		// reset state divides by one
		queue_item(CMD_DIVIDE, 32'h0000_0000);
		queue_item(CMD_DIVIDE, 32'hffff_ffff);
		queue_item(CMD_DIVIDE, 32'h1234_5678);
		// zero divisor flags and keeps the state
		queue_item(CMD_SET, 32'h0000_0000);
		queue_item(CMD_DIVIDE, 32'hffff_ffff);
		queue_item(CMD_SET, 32'h0000_0001);
		queue_item(CMD_DIVIDE, 32'ha5a5_a5a5);
		queue_item(CMD_SET, 32'hffff_ffff);
		queue_item(CMD_DIVIDE, 32'hffff_ffff);
		queue_item(CMD_DIVIDE, 32'hffff_fffe);
		queue_item(CMD_DIVIDE, 32'h0000_0000);
		queue_item(CMD_SET, 32'h8000_0000);
		queue_item(CMD_DIVIDE, 32'hffff_ffff);
		queue_item(CMD_DIVIDE, 32'h7fff_ffff);
		queue_item(CMD_SET, 32'h8000_0001);
		queue_item(CMD_DIVIDE, 32'hffff_ffff);
		queue_item(CMD_SET, 32'h0000_0003);
		queue_item(CMD_DIVIDE, 32'hffff_ffff);
		queue_item(CMD_DIVIDE, 32'h0000_0005);
		queue_item(CMD_SET, 32'h0000_0007);
		queue_item(CMD_DIVIDE, 32'h5555_5555);
		queue_item(CMD_SET, 32'h0000_0000);
		queue_item(CMD_DIVIDE, 32'hdead_beef);
		cur = 32'd7;

		while (pending.size() < ITEM_TOTAL) begin
			sel = $urandom_range(0, 15);
			if (sel == 0)
				d = '0;
			else if (sel <= 3)
				d = $urandom_range(1, 16);
			else if (sel <= 6)
				d = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
			else if (sel <= 9)
				d = $urandom_range(17, 65535);
			else
				d = $urandom();
			queue_item(CMD_SET, d);
			if (d != '0)
				cur = d;
			n = $urandom_range(1, 14);
			repeat (n) begin
				sel = $urandom_range(0, 7);
				if (sel == 0) begin
					x = $urandom_range(0, 1) ? 64'hffff_ffff : 64'd0;
				end else if (sel <= 2) begin
					// exact multiples and one below the next multiple
					x = 64'($urandom_range(0, 32'hffff_ffff / cur)) * cur;
					if ($urandom_range(0, 1))
						x = x + cur - 1;
				end else begin
					x = 64'($urandom());
				end
				queue_item(CMD_DIVIDE, x[31:0]);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || accepted_cnt != offered_cnt || quotients_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
